[design/mprq_pkg.sv]
// mprq_pkg: shared constants and helpers for the mean-pool requantizer
// no dependencies; used by mean_pool_requantize_int8
package mprq_pkg;

  localparam int ACC_W       = 32;
  localparam int SAMPLE_W    = 8;
  localparam int VALUE_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int MULT_W      = 31;
  localparam int SHIFT_W     = 6;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MULTIPLIER    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_AMOUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS          = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUNDING_MODE = 2'd3;

  // rounding modes
  localparam logic MODE_DOUBLE = 1'b0;
  localparam logic MODE_SINGLE = 1'b1;

  localparam logic signed [33:0] VALUE_MAX = 34'sd127;
  localparam logic signed [33:0] VALUE_MIN = -34'sd128;

  // right part of the exponent, 0..32
  function automatic logic [5:0] right_amount(input logic signed [SHIFT_W-1:0] sh);
    right_amount = sh[SHIFT_W-1] ? 6'(-sh) : 6'd0;
  endfunction

  // left part of the exponent, 0..31
  function automatic logic [4:0] left_amount(input logic signed [SHIFT_W-1:0] sh);
    left_amount = sh[SHIFT_W-1] ? 5'd0 : sh[4:0];
  endfunction

  // single mode total shift 31 - sh, 0..63
  function automatic logic [5:0] total_amount(input logic signed [SHIFT_W-1:0] sh);
    logic [6:0] t;
    t = 7'd31 - 7'(sh);
    total_amount = t[5:0];
  endfunction

endpackage

[design/mean_pool_requantize_int8.sv]
// mean_pool_requantize_int8: int8 channel sum with Q31 requantization and clamp
// depends on mprq_pkg

// Accepts one sample per clock while s_tready is high; a master-side stall can
// hold it low. The accumulate is a single add, so that add sets the rate. Samples
// are summed into a 32-bit wrapping accumulator. The sample flagged with tlast
// closes the window and passes through five registered stages: accumulate/left
// shift, multiply, rounding add, rounding shift, bias add and clamp. Its int8
// result shows on the master side after registers a, p, r, q and value; the sum
// restarts at zero when that sample is accepted. Samples without tlast produce no
// result. Results leave through an output register, so a waiting result does not
// block input until the five pipeline stages are all full. Configuration registers
// are to be written only while no window result is still in flight.
module mean_pool_requantize_int8 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mprq_pkg::SAMPLE_W-1:0]       s_tdata,   // [7:0] sample
  input  logic                                s_tlast,   // last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mprq_pkg::VALUE_W-1:0]        m_tdata,   // [7:0] value
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mprq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mprq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  logic [mprq_pkg::MULT_W-1:0]         multiplier;
  logic signed [mprq_pkg::SHIFT_W-1:0] shift_amount;
  logic signed [31:0]                  bias;
  logic                                rounding_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier    <= '0;
      shift_amount  <= '0;
      bias          <= '0;
      rounding_mode <= mprq_pkg::MODE_DOUBLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mprq_pkg::REG_MULTIPLIER:    multiplier    <= cfg_data[mprq_pkg::MULT_W-1:0];
        mprq_pkg::REG_SHIFT_AMOUNT:  shift_amount  <= $signed(cfg_data[mprq_pkg::SHIFT_W-1:0]);
        mprq_pkg::REG_BIAS:          bias          <= $signed(cfg_data);
        mprq_pkg::REG_ROUNDING_MODE: rounding_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control, stalls collapse bubbles
  logic v1, v2, v3, v4, out_v;
  logic free1, free2, free3, free4, free_out;

  assign free_out = !out_v || m_tready;
  assign free4    = !v4 || free_out;
  assign free3    = !v3 || free4;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign s_tready = free1;

  logic accept;
  assign accept = s_tvalid && s_tready;

  // accumulate
  logic signed [mprq_pkg::ACC_W-1:0] running_sum;
  logic signed [mprq_pkg::ACC_W-1:0] running_sum_next;
  logic signed [31:0]                x_next;

  assign running_sum_next = running_sum
                          + mprq_pkg::ACC_W'($signed(s_tdata));
  assign x_next = 32'(running_sum_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (accept) begin
      running_sum <= s_tlast ? '0 : running_sum_next;
    end
  end

  // stage 1: multiplier operand, left shift in double mode wraps at 32 bits
  logic signed [31:0] a;
  logic signed [31:0] a_next;

  assign a_next = (rounding_mode == mprq_pkg::MODE_SINGLE) ? x_next
                : (x_next <<< mprq_pkg::left_amount(shift_amount));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (free1) begin
      v1 <= accept && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      a <= a_next;
    end
  end

  // stage 2: product
  logic signed [63:0] p;
  logic signed [63:0] p_next;
  logic signed [63:0] a_ext, m_ext;

  assign a_ext  = 64'(a);
  assign m_ext  = 64'($signed({1'b0, multiplier}));
  assign p_next = a_ext * m_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (free2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (free2) begin
      p <= p_next;
    end
  end

  // stage 3: rounding term
  // double mode: truncating (ab + nudge) / 2^31 equals floor((ab + 2^30) / 2^31)
  logic signed [63:0] r;
  logic signed [63:0] r_next;
  logic signed [63:0] rnd;
  logic [5:0]         total;

  assign total = mprq_pkg::total_amount(shift_amount);

  always_comb begin
    if (rounding_mode == mprq_pkg::MODE_DOUBLE) begin
      rnd = 64'sd1 <<< 30;
    end else if (total == 6'd0) begin
      rnd = '0;
    end else begin
      rnd = 64'sd1 <<< (total - 6'd1);
    end
  end

  assign r_next = p + rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (free3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (free3) begin
      r <= r_next;
    end
  end

  // stage 4: arithmetic right shift, plus round-half-away bit in double mode
  logic signed [31:0] q;
  logic signed [31:0] q_next;
  logic               inc;
  logic               inc_next;
  logic [5:0]         e;
  logic [5:0]         amt;
  logic signed [63:0] r_shr;
  logic [63:0]        half_bit;
  logic [63:0]        low_mask;

  assign e   = mprq_pkg::right_amount(shift_amount);
  assign amt = (rounding_mode == mprq_pkg::MODE_DOUBLE) ? 6'(7'd31 + 7'(e)) : total;

  assign r_shr  = r >>> amt;
  assign q_next = r_shr[31:0];

  // bits of the high word below the half bit
  assign half_bit = 64'd1 << (7'd30 + 7'(e));
  assign low_mask = (half_bit - 64'd1) & ~((64'd1 << 31) - 64'd1);

  assign inc_next = (rounding_mode == mprq_pkg::MODE_DOUBLE) && (e != 6'd0)
                 && ((r & half_bit) != '0)
                 && (!r[63] || ((r & low_mask) != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (free4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (free4) begin
      q   <= q_next;
      inc <= inc_next;
    end
  end

  // stage 5: bias and clamp into the output register
  logic signed [33:0]             y;
  logic [mprq_pkg::VALUE_W-1:0]   value_next;
  logic [mprq_pkg::VALUE_W-1:0]   value;

  assign y = 34'(q) + 34'(bias) + 34'($signed({1'b0, inc}));

  always_comb begin
    priority if (y > mprq_pkg::VALUE_MAX) begin
      value_next = mprq_pkg::VALUE_MAX[mprq_pkg::VALUE_W-1:0];
    end else if (y < mprq_pkg::VALUE_MIN) begin
      value_next = mprq_pkg::VALUE_MIN[mprq_pkg::VALUE_W-1:0];
    end else begin
      value_next = y[mprq_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (free_out) begin
      out_v <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (free_out) begin
      value <= value_next;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = value;

  // checks
  a_sum_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> running_sum == '0)
    else $error("running sum not cleared after last item");

  a_last_enters: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> v1)
    else $error("last item did not enter the pipeline");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && v3 && v4 && out_v)
    else $error("input stalled with a bubble in the pipeline");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    v4 && !free_out |=> v4 && out_v)
    else $error("pending result dropped during stall");

endmodule
